[sv/png_ancillary_chunk_filter_defines.svh]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PNG_ANCILLARY_CHUNK_FILTER_DEFINES_SVH
`define PNG_ANCILLARY_CHUNK_FILTER_DEFINES_SVH

// same-cycle implication
`define ACF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/png_acf_pkg.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - package
// Parser phases, queue command format and PNG constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package png_acf_pkg;

  typedef enum logic [1:0] {
    PH_SIG,
    PH_PREFIX,
    PH_BODY,
    PH_ERR
  } phase_e;

  // one queue entry: either a single result or a release of the held prefix
  typedef struct packed {
    logic        rel;
    logic [7:0]  data;
    logic        vld;
    logic        done;
    logic        fail;
    logic [63:0] prefix;
  } cmd_t;

  localparam int unsigned BODY_W = 33;
  localparam logic [BODY_W-1:0] CRC_BYTES = BODY_W'(4);
  localparam int unsigned CASE_BIT = 5;

  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
  };

  localparam int unsigned N_KEPT = 5;
  localparam logic [31:0] KEPT_TYPES [N_KEPT] = '{
    32'h624b4744, 32'h74524e53, 32'h6163544c, 32'h6663544c, 32'h66644154
  };

endpackage

[sv/png_acf_front.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - front end
// Parses signature, chunk prefixes and bodies; issues at most one command per accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_acf_front
  import png_acf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  phase_e              phase_q, phase_d;
  logic [2:0]          idx_q, idx_d;
  logic [63:0]         prefix_q, prefix_d;
  logic [BODY_W-1:0]   body_q, body_d;
  logic                keep_q, keep_d;

  logic                acc;
  logic                emit;
  logic [63:0]         prefix_new;
  logic [31:0]         chunk_type;
  logic                type_kept;
  logic [BODY_W-1:0]   body_dec;
  logic                body_ok;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign prefix_new = {prefix_q[55:0], in_byte_i};
  assign chunk_type = prefix_new[31:0];
  assign body_dec   = body_q - BODY_W'(1);
  assign body_ok    = (body_dec == '0);

  always_comb begin
    type_kept = !(chunk_type[24 + CASE_BIT] || chunk_type[16 + CASE_BIT]);
    for (int k = 0; k < N_KEPT; k++) begin
      if (chunk_type == KEPT_TYPES[k]) type_kept = 1'b1;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    prefix_d = prefix_q;
    body_d   = body_q;
    keep_d   = keep_q;
    emit     = 1'b0;
    q_cmd_o  = '{rel: 1'b0, data: in_byte_i, vld: 1'b1, done: 1'b0, fail: 1'b0,
                 prefix: prefix_new};
    unique case (phase_q)
      PH_SIG: begin
        if (in_byte_i != SIG_BYTES[idx_q]) begin
          phase_d = PH_ERR;
          if (is_last_i) begin
            emit    = 1'b1;
            q_cmd_o.vld  = 1'b0;
            q_cmd_o.data = '0;
            q_cmd_o.done = 1'b1;
            q_cmd_o.fail = 1'b1;
          end
        end else if (idx_q == 3'd7) begin
          emit         = 1'b1;
          q_cmd_o.done = is_last_i;
          phase_d      = PH_PREFIX;
          idx_d        = '0;
        end else if (is_last_i) begin
          emit         = 1'b1;
          q_cmd_o.vld  = 1'b0;
          q_cmd_o.data = '0;
          q_cmd_o.done = 1'b1;
          q_cmd_o.fail = 1'b1;
        end else begin
          emit  = 1'b1;
          idx_d = idx_q + 3'd1;
        end
      end
      PH_PREFIX: begin
        if (is_last_i) begin
          emit         = 1'b1;
          q_cmd_o.vld  = 1'b0;
          q_cmd_o.data = '0;
          q_cmd_o.done = 1'b1;
          q_cmd_o.fail = 1'b1;
        end else begin
          prefix_d = prefix_new;
          if (idx_q != 3'd7) begin
            idx_d = idx_q + 3'd1;
          end else begin
            body_d      = {1'b0, prefix_new[63:32]} + CRC_BYTES;
            keep_d      = type_kept;
            phase_d     = PH_BODY;
            idx_d       = '0;
            emit        = type_kept;
            q_cmd_o.rel = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (is_last_i) begin
          emit         = 1'b1;
          q_cmd_o.vld  = body_ok && keep_q;
          q_cmd_o.data = (body_ok && keep_q) ? in_byte_i : '0;
          q_cmd_o.done = 1'b1;
          q_cmd_o.fail = !body_ok;
        end else begin
          body_d = body_dec;
          if (body_ok) begin
            phase_d = PH_PREFIX;
            idx_d   = '0;
          end
          emit = keep_q;
        end
      end
      PH_ERR: begin
        if (is_last_i) begin
          emit         = 1'b1;
          q_cmd_o.vld  = 1'b0;
          q_cmd_o.data = '0;
          q_cmd_o.done = 1'b1;
          q_cmd_o.fail = 1'b1;
        end
      end
      default: ;
    endcase
    // end of file: back to reset state for the next one
    if (is_last_i) begin
      phase_d = PH_SIG;
      idx_d   = '0;
      body_d  = '0;
      keep_d  = 1'b0;
    end
  end

  assign q_push_o = acc && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      idx_q   <= '0;
      body_q  <= '0;
      keep_q  <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      body_q  <= body_d;
      keep_q  <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) prefix_q <= prefix_d;
  end

endmodule

[sv/png_acf_queue.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_acf_queue
  import png_acf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

endmodule

[sv/png_acf_back.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - back end
// Expands queued commands into result beats through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_acf_back
  import png_acf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       stream_done_o,
  output logic       fail_o,
  output logic       run_end_o
);

  logic [2:0] beat_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       bvld_q, done_q, fail_q, end_q;

  logic       load;
  logic       rel_last;
  logic [2:0] sel;
  logic [7:0] rel_byte;

  assign load     = !empty_i && (!valid_q || out_ready_i);
  assign rel_last = (beat_q == 3'd7);
  assign pop_o    = load && (!head_i.rel || rel_last);
  assign sel      = 3'd7 - beat_q;
  assign rel_byte = head_i.prefix[{sel, 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else begin
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      if (load && head_i.rel) beat_q <= beat_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.rel) begin
        byte_q <= rel_byte;
        bvld_q <= 1'b1;
        done_q <= 1'b0;
        fail_q <= 1'b0;
        end_q  <= rel_last;
      end else begin
        byte_q <= head_i.data;
        bvld_q <= head_i.vld;
        done_q <= head_i.done;
        fail_q <= head_i.fail;
        end_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvld_q;
  assign stream_done_o = done_q;
  assign fail_o        = fail_q;
  assign run_end_o     = end_q;

endmodule

[sv/png_ancillary_chunk_filter.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - top level
// Strips ancillary and private chunks, except a fixed list of kept types, from a PNG byte stream.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle. Every byte passes the front end combinationally
// into the queue; a kept chunk's 8 held prefix bytes come out as 8 beats from the
// back end, with the command queue (FIFO_DEPTH entries) absorbing the burst, so
// input stalls only when the queue fills. A result passes the queue and the back
// end's output register. On fail the consumer discards the file's output.
`timescale 1ns / 1ps

module png_ancillary_chunk_filter
  import png_acf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       stream_done_o,
  output logic       fail_o,
  output logic       run_end_o
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  png_acf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .is_last_i  (is_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  png_acf_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  png_acf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .stream_done_o (stream_done_o),
    .fail_o        (fail_o),
    .run_end_o     (run_end_o)
  );

endmodule

[sv/png_acf_checker.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - port checker
// Assertions on the top-level result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "png_ancillary_chunk_filter_defines.svh"

module png_acf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       stream_done_o,
  input logic       fail_o,
  input logic       run_end_o
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  `ACF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(run_end_o) && $stable(stream_done_o), "stalled result beat changed")
  `ACF_ASSERT_NOW(a_fail_done, out_valid_o && fail_o, stream_done_o && !byte_valid_o, "fail without done or with data")
  `ACF_ASSERT_NOW(a_done_end, out_valid_o && stream_done_o, run_end_o, "done beat not last of its run")
  `ACF_ASSERT_NOW(a_zero_byte, out_valid_o && !byte_valid_o, out_byte_o == 8'h00 && stream_done_o, "empty beat carries data or lacks done")
  `ACF_ASSERT_NEXT(a_reset_idle, !$past(rst_ni) && !in_beat, !out_valid_o, "result beat right after reset")

endmodule

bind png_ancillary_chunk_filter png_acf_checker u_checker (.*);

[tb/png_ancillary_chunk_filter_tb.sv]
// ----------------------------------------------------------------------------
// PNG ancillary chunk filter - testbench
// Sends directed and random PNG byte streams through the filter, predicts the
// trimmed stream beat by beat and compares every output field, with random
// idling on both sides and one long output hold-off that fills the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_ancillary_chunk_filter_tb;
  import png_acf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       done;
    logic       fail;
    logic       last;
  } out_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       is_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       stream_done_o;
  logic       fail_o;
  logic       run_end_o;

  png_ancillary_chunk_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .stream_done_o (stream_done_o),
    .fail_o        (fail_o),
    .run_end_o     (run_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  out_beat_t        trimmed_stream [$];
  logic [7:0]       file_bytes [$];
  int               fail_count = 0;
  int               cycle_count = 0;
  int               beats_sent = 0;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               hold_len = 0;
  int               hold_reqs = 0;
  int               hold_taken = 0;
  int               hold_cycles = 0;

  // parser state of the predictor
  phase_e           parse_phase;
  logic [2:0]       field_pos;
  logic [7:0]       held_prefix [8];
  logic [BODY_W-1:0] chunk_left;
  logic             chunk_kept;

  function automatic void clear_parser();
    parse_phase = PH_SIG;
    field_pos   = '0;
    chunk_left  = '0;
    chunk_kept  = 1'b0;
  endfunction

  function automatic void push_beat(logic [7:0] b, logic v, logic d, logic f, logic l);
    out_beat_t e;
    e.data = v ? b : 8'h00;
    e.vld  = v;
    e.done = d;
    e.fail = d & f;
    e.last = l;
    trimmed_stream.push_back(e);
  endfunction

  function automatic logic type_survives();
    logic [31:0] ctype;
    ctype = {held_prefix[4], held_prefix[5], held_prefix[6], held_prefix[7]};
    if (!held_prefix[4][CASE_BIT] && !held_prefix[5][CASE_BIT]) return 1'b1;
    for (int i = 0; i < N_KEPT; i++) begin
      if (ctype == KEPT_TYPES[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void abort_file();
    push_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    clear_parser();
  endfunction

  function automatic void filter_byte(logic [7:0] b, logic last);
    logic ok;
    case (parse_phase)
      PH_SIG: begin
        if (b != SIG_BYTES[field_pos]) begin
          if (last) abort_file();
          else parse_phase = PH_ERR;
        end else if (field_pos == 3'd7) begin
          push_beat(b, 1'b1, last, 1'b0, 1'b1);
          if (last) clear_parser();
          else begin
            parse_phase = PH_PREFIX;
            field_pos   = '0;
          end
        end else if (last) begin
          abort_file();
        end else begin
          field_pos = field_pos + 3'd1;
          push_beat(b, 1'b1, 1'b0, 1'b0, 1'b1);
        end
      end
      PH_PREFIX: begin
        if (last) abort_file();
        else begin
          held_prefix[field_pos] = b;
          if (field_pos != 3'd7) field_pos = field_pos + 3'd1;
          else begin
            chunk_left = BODY_W'({held_prefix[0], held_prefix[1], held_prefix[2],
                                  held_prefix[3]}) + CRC_BYTES;
            chunk_kept  = type_survives();
            parse_phase = PH_BODY;
            field_pos   = '0;
            if (chunk_kept) begin
              for (int i = 0; i < 8; i++) push_beat(held_prefix[i], 1'b1, 1'b0, 1'b0, i == 7);
            end
          end
        end
      end
      PH_BODY: begin
        chunk_left = chunk_left - BODY_W'(1);
        if (last) begin
          ok = (chunk_left == '0);
          push_beat(b, ok & chunk_kept, 1'b1, !ok, 1'b1);
          clear_parser();
        end else begin
          if (chunk_left == '0) begin
            parse_phase = PH_PREFIX;
            field_pos   = '0;
          end
          if (chunk_kept) push_beat(b, 1'b1, 1'b0, 1'b0, 1'b1);
        end
      end
      default: begin
        if (last) abort_file();
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (trimmed_stream.size() == 0) begin
        $error("unexpected beat: out_byte %0h", out_byte_o);
        fail_count++;
      end else begin
        want = trimmed_stream.pop_front();
        check_field("out_byte", want.data, out_byte_o);
        check_field("byte_valid", want.vld, byte_valid_o);
        check_field("stream_done", want.done, stream_done_o);
        check_field("fail", want.fail, fail_o);
        check_field("run_end", want.last, run_end_o);
      end
    end
  end

  // receiver: random stalls, plus an explicit hold-off counted here
  always @(negedge clk_i) begin
    if (hold_taken != hold_reqs) begin
      hold_taken  <= hold_reqs;
      hold_cycles <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("png_ancillary_chunk_filter verification failed");
      $finish;
    end
  end

  task automatic send_beat(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    filter_byte(b, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_beat(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic wait_stream_idle();
    in_valid_i <= 1'b0;
    while (trimmed_stream.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void start_file();
    file_bytes.delete();
    foreach (SIG_BYTES[i]) file_bytes.push_back(SIG_BYTES[i]);
  endfunction

  function automatic void add_chunk(logic [31:0] len, logic [31:0] ctype, int body_n);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(len[8*i +: 8]);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(ctype[8*i +: 8]);
    repeat (body_n) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_random_chunk();
    int sel;
    logic [31:0] len;
    logic [31:0] ctype;
    sel = $urandom_range(99);
    len = (sel < 5) ? 32'($urandom) : 32'($urandom_range(5));
    case ($urandom_range(2))
      0: ctype = KEPT_TYPES[$urandom_range(N_KEPT - 1)];
      1: ctype = 32'($urandom) & 32'hdfdf_ffff;
      default: ctype = 32'($urandom);
    endcase
    // a huge length only gets a few body bytes; the file then ends truncated
    add_chunk(len, ctype, (sel < 5) ? $urandom_range(6) : int'(len) + 4);
  endfunction

  task automatic random_file();
    int kind;
    int pos;
    kind = $urandom_range(99);
    start_file();
    if (kind < 8) begin
      pos = $urandom_range(7);
      file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(255, 1));
      repeat ($urandom_range(4)) file_bytes.push_back(8'($urandom));
    end else if (kind < 14) begin
      pos = $urandom_range(7, 1);
      while (file_bytes.size() > pos) void'(file_bytes.pop_back());
    end else begin
      repeat ($urandom_range(3)) add_random_chunk();
      if ($urandom_range(99) < 20 && file_bytes.size() > 9) begin
        pos = $urandom_range(file_bytes.size() - 1, 9);
        while (file_bytes.size() > pos) void'(file_bytes.pop_back());
      end
    end
    send_file();
  endtask

  task automatic test_signature_cases();
    file_bytes = '{8'h89};
    send_file();
    start_file();
    void'(file_bytes.pop_back());
    send_file();
    file_bytes = '{8'h89, 8'h00, 8'hff, 8'h50};
    send_file();
    file_bytes = '{8'h00};
    send_file();
    start_file();
    send_file();
    wait_stream_idle();
  endtask

  task automatic test_chunk_cases();
    start_file();
    add_chunk(32'd1, 32'h49484452, 5);
    add_chunk(32'd0, 32'h74455874, 4);
    add_chunk(32'd0, 32'h624b4744, 4);
    add_chunk(32'd0, 32'h49454e44, 4);
    send_file();
    start_file();
    add_chunk(32'd1, 32'h7a545874, 5);
    send_file();
    start_file();
    add_chunk(32'hffff_ffff, 32'h49444154, 3);
    send_file();
    start_file();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    send_file();
    wait_stream_idle();
  endtask

  task automatic test_random_files(int idle, int stall, int budget);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = beats_sent + budget;
    while (beats_sent < stop_at) random_file();
    wait_stream_idle();
  endtask

  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 150;
    hold_reqs++;
    start_file();
    for (int i = 0; i < 4; i++) begin
      add_chunk(32'd0, (i % 2 == 0) ? 32'h49444154 : KEPT_TYPES[i % N_KEPT], 4);
    end
    send_file();
    wait_stream_idle();
  endtask

  initial begin
    clear_parser();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_signature_cases();
    test_chunk_cases();
    test_random_files(0, 0, 20);
    test_random_files(54, 0, 20);
    test_random_files(0, 54, 20);
    test_random_files(23, 23, 20);
    test_output_hold();
    if (fail_count == 0) begin
      $display("png_ancillary_chunk_filter verification clean");
    end else begin
      $display("png_ancillary_chunk_filter verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/png_acf_pkg.sv
sv/png_acf_front.sv
sv/png_acf_queue.sv
sv/png_acf_back.sv
sv/png_ancillary_chunk_filter.sv
sv/png_acf_checker.sv
tb/png_ancillary_chunk_filter_tb.sv
